// ===== design/dsqm_pkg.sv =====
package dsqm_pkg;

    // Packet size bound and derived byte-position width
    localparam int MAX_PACKET_BYTES = 512;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int HEADER_BYTES     = 12;

    // Field widths
    localparam int DATA_W    = 8;
    localparam int QIDX_W    = 16;
    localparam int PATTERN_W = 48;
    localparam int QTYPE_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = PATTERN_W;
    localparam int LEFT_W    = 8;
    localparam int BIQ_W     = 3;

    // Header byte positions
    localparam logic [POS_W-1:0] POS_FLAGS   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_QD_HI   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_QD_LO   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_LIMIT   = POS_W'(MAX_PACKET_BYTES);

    // Protocol constants
    localparam int                  QR_BIT        = 7;
    localparam logic [DATA_W-1:0]   PTR_MASK      = 8'hC0;
    localparam logic [BIQ_W-1:0]    WINDOW_BYTES  = 3'd6;
    localparam logic [LEFT_W-1:0]   TYPE_BYTES    = 8'd2;
    localparam logic [LEFT_W-1:0]   TAIL_BYTES    = 8'd4;

    // Register reset values
    localparam logic [PATTERN_W-1:0] PATTERN_RST = 48'h5F6D69646932;
    localparam logic [QTYPE_W-1:0]   QTYPE_RST   = 16'h0021;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_PATTERN = 1'b0,
        CFG_QUERY_TYPE    = 1'b1
    } t_cfg_idx;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN    = 3'd1,
        PH_LABEL  = 3'd2,
        PH_PTR    = 3'd3,
        PH_TAIL   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

endpackage

// ===== design/dsqm_in_if.sv =====
interface dsqm_in_if import dsqm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== design/dsqm_out_if.sv =====
interface dsqm_out_if import dsqm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [QIDX_W-1:0] question_index;

    modport source (output valid, output question_index, input ready);
    modport sink   (input valid, input question_index, output ready);
endinterface

// ===== design/dns_srv_query_matcher.sv =====
// A result beat passes the byte register and then the result register before it goes valid.
// Throughput: one packet byte per cycle; the byte register and the result
// register form a two-stage pipe, so input stalls only while a result waits.
// Reset (i_rst_n low, synchronous) empties both stages, restores the match
// pattern and query type defaults, and returns the parser to the header phase.
module dns_srv_query_matcher import dsqm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dsqm_in_if.sink               i_in,
    dsqm_out_if.source            o_out
);

    // Configuration
    logic [PATTERN_W-1:0] r_pattern;
    logic [QTYPE_W-1:0]   r_qtype;

    // Byte stage
    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_data;
    logic              r_in_last;

    // Result stage
    logic              r_out_valid;
    logic [QIDX_W-1:0] r_out_index;

    // Parser state
    t_phase               r_phase, n_phase;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_resp, n_resp;
    logic [QIDX_W-1:0]    r_total, n_total;
    logic [QIDX_W-1:0]    r_cnt, n_cnt;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic [PATTERN_W-1:0] r_recent, n_recent;
    logic [BIQ_W-1:0]     r_biq, n_biq;
    logic                 r_seen, n_seen;
    logic [QTYPE_W-1:0]   r_type, n_type;

    logic                 out_free;
    logic                 consume;
    logic                 emit;
    logic [PATTERN_W-1:0] shifted;

    // Handshake: a byte moves on when the result slot is free or draining
    assign out_free   = !r_out_valid || o_out.ready;
    assign consume    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    assign o_out.valid          = r_out_valid;
    assign o_out.question_index = r_out_index;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= PATTERN_RST;
            r_qtype   <= QTYPE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MATCH_PATTERN: r_pattern <= i_cfg_data;
                CFG_QUERY_TYPE:    r_qtype   <= i_cfg_data[QTYPE_W-1:0];
            endcase
        end
    end

    // Byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_data <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= consume && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_out_index <= r_cnt;
        end
    end

    // Parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_resp   <= 1'b0;
            r_total  <= '0;
            r_cnt    <= '0;
            r_left   <= '0;
            r_recent <= '0;
            r_biq    <= '0;
            r_seen   <= 1'b0;
            r_type   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_resp   <= n_resp;
            r_total  <= n_total;
            r_cnt    <= n_cnt;
            r_left   <= n_left;
            r_recent <= n_recent;
            r_biq    <= n_biq;
            r_seen   <= n_seen;
            r_type   <= n_type;
        end
    end

    // Per-byte parse step
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_resp   = r_resp;
        n_total  = r_total;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_recent = r_recent;
        n_biq    = r_biq;
        n_seen   = r_seen;
        n_type   = r_type;
        emit     = 1'b0;
        shifted  = {r_recent[PATTERN_W-DATA_W-1:0], r_in_data};

        if (consume && (r_pos < POS_LIMIT)) begin
            n_pos = r_pos + POS_W'(1);
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_FLAGS) begin
                        n_resp = r_in_data[QR_BIT];
                    end
                    if (r_pos == POS_QD_HI) begin
                        n_total = {r_in_data, {DATA_W{1'b0}}};
                    end
                    if (r_pos == POS_QD_LO) begin
                        n_total = {r_total[QIDX_W-1:DATA_W], r_in_data};
                    end
                    if (r_pos == POS_HDR_END) begin
                        n_cnt = '0;
                        if (r_resp || (r_total == '0)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase  = PH_LEN;
                            n_left   = '0;
                            n_recent = '0;
                            n_biq    = '0;
                            n_seen   = 1'b0;
                            n_type   = '0;
                        end
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    // six-byte window over the question's own bytes
                    n_recent = shifted;
                    if (r_biq < WINDOW_BYTES) begin
                        n_biq = r_biq + BIQ_W'(1);
                    end
                    if ((n_biq >= WINDOW_BYTES) && (shifted == r_pattern)) begin
                        n_seen = 1'b1;
                    end

                    case (r_phase)
                        PH_LEN: begin
                            if (r_in_data == '0) begin
                                n_phase = PH_TAIL;
                                n_left  = '0;
                            end else if ((r_in_data & PTR_MASK) == PTR_MASK) begin
                                n_phase = PH_PTR;
                            end else begin
                                n_left  = r_in_data;
                                n_phase = PH_LABEL;
                            end
                        end
                        PH_LABEL: begin
                            n_left = r_left - LEFT_W'(1);
                            if (n_left == '0) begin
                                n_phase = PH_LEN;
                            end
                        end
                        PH_PTR: begin
                            n_phase = PH_TAIL;
                            n_left  = '0;
                        end
                        default: begin
                            // type word, then class word
                            if (r_left < TYPE_BYTES) begin
                                n_type = {r_type[QTYPE_W-DATA_W-1:0], r_in_data};
                            end
                            n_left = r_left + LEFT_W'(1);
                            if (n_left >= TAIL_BYTES) begin
                                emit  = n_seen && (n_type == r_qtype);
                                n_cnt = r_cnt + QIDX_W'(1);
                                if (n_cnt >= r_total) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase  = PH_LEN;
                                    n_left   = '0;
                                    n_recent = '0;
                                    n_biq    = '0;
                                    n_seen   = 1'b0;
                                    n_type   = '0;
                                end
                            end
                        end
                    endcase
                end
            endcase
        end

        // packet end: back to header, parser state cleared, configuration kept
        if (consume && r_in_last) begin
            n_phase  = PH_HEADER;
            n_pos    = '0;
            n_resp   = 1'b0;
            n_total  = '0;
            n_cnt    = '0;
            n_left   = '0;
            n_recent = '0;
            n_biq    = '0;
            n_seen   = 1'b0;
            n_type   = '0;
        end
    end

    // Checks
    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_pos <= POS_HDR_END))
        else $error("header phase past header length");

    a_window_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_biq <= WINDOW_BYTES)
        else $error("window byte count overflow");

    a_question_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_LEN) || (r_phase == PH_LABEL) || (r_phase == PH_PTR) ||
         (r_phase == PH_TAIL)) |-> (r_cnt < r_total))
        else $error("question index beyond question count");

    a_emit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && emit) |=> (r_out_valid && (r_out_index == $past(r_cnt))))
        else $error("result beat lost or wrong index");

    a_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && $stable(r_in_data)))
        else $error("pending byte dropped");

endmodule
